// ===== hw/rtl/arfc_pkg.sv =====
// package: types, constants and codes shared by the anchor rssi freshness collector
`default_nettype none

package arfc_pkg;

	localparam int NUM_ANCHORS_DEF = 3;
	localparam int MAX_ANCHORS = 3;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	localparam logic [1:0] REG_FRESH_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_MOBILE_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_STATUS_INTERVAL = 2'd2;

	localparam logic [15:0] FRESH_TIMEOUT_RST = 16'd200;
	localparam logic [15:0] MOBILE_TIMEOUT_RST = 16'd1500;
	localparam logic [15:0] STATUS_INTERVAL_RST = 16'd1000;

	localparam logic signed [15:0] READY_MARK = 16'sh7FFF;
	localparam logic signed [15:0] UNAVAIL_MARK = 16'shFF81;
	localparam logic signed [15:0] RSSI_RESET = 16'shFF9C;

	typedef enum logic [2:0] {
		ST_NOT_CONNECTED = 3'd0,
		ST_RX_NO_RSSI = 3'd1,
		ST_FRESH = 3'd2,
		ST_STALE = 3'd3,
		ST_WAITING = 3'd4
	} anc_status_t;

	typedef struct packed {
		logic kind;
		logic [7:0] anchor_index;
		logic signed [15:0] rssi_value;
		logic [31:0] now_ms;
	} req_t;

	typedef struct packed {
		logic all_fresh;
		logic signed [15:0] rssi_first;
		logic signed [15:0] rssi_second;
		logic signed [15:0] rssi_third;
		logic [1:0] fresh_count;
		logic status_due;
		logic mobile_working;
		logic [2:0] status_first;
		logic [2:0] status_second;
		logic [2:0] status_third;
	} rsp_t;

	typedef struct packed {
		logic [15:0] fresh_timeout_ms;
		logic [15:0] mobile_timeout_ms;
		logic [15:0] status_interval_ms;
	} cfg_t;

	typedef struct packed {
		logic report;
		logic clear;
	} anc_ctl_t;

	typedef struct packed {
		logic fresh;
		anc_status_t status;
		logic signed [15:0] rssi;
	} anc_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/arfc_regs.sv =====
// configuration register file behind the apb port
`default_nettype none

module arfc_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [arfc_pkg::PADDR_W-1:0] paddr,
	input wire logic [arfc_pkg::PDATA_W-1:0] pwdata,
	output logic [arfc_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	output arfc_pkg::cfg_t cfg
);
	import arfc_pkg::*;

	cfg_t cfg_q;
	logic [1:0] reg_idx;
	logic wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fresh_timeout_ms <= FRESH_TIMEOUT_RST;
			cfg_q.mobile_timeout_ms <= MOBILE_TIMEOUT_RST;
			cfg_q.status_interval_ms <= STATUS_INTERVAL_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FRESH_TIMEOUT: cfg_q.fresh_timeout_ms <= pwdata[15:0];
				REG_MOBILE_TIMEOUT: cfg_q.mobile_timeout_ms <= pwdata[15:0];
				REG_STATUS_INTERVAL: cfg_q.status_interval_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FRESH_TIMEOUT: prdata = {16'b0, cfg_q.fresh_timeout_ms};
			REG_MOBILE_TIMEOUT: prdata = {16'b0, cfg_q.mobile_timeout_ms};
			REG_STATUS_INTERVAL: prdata = {16'b0, cfg_q.status_interval_ms};
			default: prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/arfc_anchor.sv =====
// per-anchor slot: stored rssi, flags, report time, freshness and status
`default_nettype none

module arfc_anchor (
	input wire logic clk,
	input wire logic arst_n,
	input wire arfc_pkg::anc_ctl_t ctl,
	input wire logic signed [15:0] rssi_value,
	input wire logic [31:0] now_ms,
	input wire logic [15:0] fresh_timeout_ms,
	output arfc_pkg::anc_stat_t stat
);
	import arfc_pkg::*;

	logic signed [15:0] rssi_q;
	logic rcv_q;
	logic rdy_q;
	logic [31:0] rtime_q;
	logic [31:0] age;
	logic recent;
	logic unavail;
	logic fresh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rssi_q <= RSSI_RESET;
			rcv_q <= 1'b0;
			rdy_q <= 1'b0;
			rtime_q <= '0;
		end else begin
			if (ctl.clear) begin
				rcv_q <= 1'b0;
			end
			if (ctl.report) begin
				rdy_q <= 1'b1;
				if (rssi_value != READY_MARK) begin
					rcv_q <= 1'b1;
					rtime_q <= now_ms;
					if (rssi_value != UNAVAIL_MARK) begin
						rssi_q <= rssi_value;
					end
				end
			end
		end
	end

	assign age = now_ms - rtime_q;
	assign recent = rcv_q && (age <= {16'b0, fresh_timeout_ms});
	assign unavail = (rssi_q == UNAVAIL_MARK);
	assign fresh = recent && !unavail;

	always_comb begin
		stat.fresh = fresh;
		stat.rssi = rssi_q;
		if (!rdy_q) begin
			stat.status = ST_NOT_CONNECTED;
		end else if (recent && unavail) begin
			stat.status = ST_RX_NO_RSSI;
		end else if (fresh) begin
			stat.status = ST_FRESH;
		end else if (rcv_q) begin
			stat.status = ST_STALE;
		end else begin
			stat.status = ST_WAITING;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/arfc_core.sv =====
// anchor slots, mobile and status timers, and evaluation of one request
`default_nettype none

module arfc_core #(
	parameter int NUM_ANCHORS = arfc_pkg::NUM_ANCHORS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic fire,
	input wire arfc_pkg::req_t req,
	input wire arfc_pkg::cfg_t cfg,
	output arfc_pkg::rsp_t rsp
);
	import arfc_pkg::*;

	anc_stat_t st [MAX_ANCHORS];
	logic is_report;
	logic is_eval;
	logic in_range;
	logic all_fresh;
	logic due;
	logic mob_ok;
	logic [31:0] mob_age;
	logic [31:0] stat_age;
	logic [31:0] mob_time_q;
	logic [31:0] stat_time_q;
	logic mob_seen_q;

	assign is_report = fire && (req.kind == KIND_REPORT);
	assign is_eval = fire && (req.kind == KIND_EVAL);
	assign in_range = req.anchor_index < 8'(NUM_ANCHORS);
	assign all_fresh = st[0].fresh && st[1].fresh && st[2].fresh;

	for (genvar i = 0; i < MAX_ANCHORS; i++) begin : g_slot
		if (i < NUM_ANCHORS) begin : g_anc
			anc_ctl_t ctl;
			assign ctl.report = is_report && (req.anchor_index == 8'(i));
			assign ctl.clear = is_eval && all_fresh;
			arfc_anchor u_anc (
				.clk(clk),
				.arst_n(arst_n),
				.ctl(ctl),
				.rssi_value(req.rssi_value),
				.now_ms(req.now_ms),
				.fresh_timeout_ms(cfg.fresh_timeout_ms),
				.stat(st[i])
			);
		end else begin : g_none
			assign st[i] = '0;
		end
	end

	assign stat_age = req.now_ms - stat_time_q;
	assign mob_age = req.now_ms - mob_time_q;
	assign due = stat_age >= {16'b0, cfg.status_interval_ms};
	assign mob_ok = mob_seen_q && (mob_age <= {16'b0, cfg.mobile_timeout_ms});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mob_time_q <= '0;
			stat_time_q <= '0;
			mob_seen_q <= 1'b0;
		end else begin
			if (is_report && in_range && (req.rssi_value != READY_MARK)) begin
				mob_time_q <= req.now_ms;
				mob_seen_q <= 1'b1;
			end
			if (is_eval && due) begin
				stat_time_q <= req.now_ms;
			end
		end
	end

	always_comb begin
		rsp.all_fresh = all_fresh;
		rsp.rssi_first = all_fresh ? st[0].rssi : '0;
		rsp.rssi_second = all_fresh ? st[1].rssi : '0;
		rsp.rssi_third = all_fresh ? st[2].rssi : '0;
		rsp.fresh_count = 2'(st[0].fresh) + 2'(st[1].fresh) + 2'(st[2].fresh);
		rsp.status_due = due;
		rsp.mobile_working = due && mob_ok;
		rsp.status_first = due ? st[0].status : ST_NOT_CONNECTED;
		rsp.status_second = due ? st[1].status : ST_NOT_CONNECTED;
		rsp.status_third = due ? st[2].status : ST_NOT_CONNECTED;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/anchor_rssi_freshness_collector.sv =====
// top level: anchor rssi freshness collector
//
// request channel (req_valid/req_ready/req): kind selects an anchor report or an
// evaluate pass; reports update the anchor slot and give no response, evaluate
// passes give exactly one response on rsp_valid/rsp_ready/rsp.
// a request is held in an input register and processed against the anchor state
// as it leaves that register; an evaluate response is loaded into the output
// register as the evaluate leaves, and an evaluate waits while the output is held.
// throughput is one request per cycle, set by the single input register, while
// the response side does not stall; a report in the input register never waits
// on the response side.
// when the receiver stalls, the held response stays put, one evaluate request
// waits in the input register, and req_ready drops until the response is taken.
// configuration goes through the apb port (pready always high, no wait states).
// reset clears the anchor flags and times, sets stored rssi to -100 and loads
// the default timeouts; no request or response is pending after reset.
`default_nettype none

module anchor_rssi_freshness_collector #(
	parameter int NUM_ANCHORS = arfc_pkg::NUM_ANCHORS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire arfc_pkg::req_t req,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output arfc_pkg::rsp_t rsp,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [arfc_pkg::PADDR_W-1:0] paddr,
	input wire logic [arfc_pkg::PDATA_W-1:0] pwdata,
	output logic [arfc_pkg::PDATA_W-1:0] prdata,
	output logic pready
);
	import arfc_pkg::*;

	cfg_t cfg;
	req_t req_s1;
	logic valid_s1;
	rsp_t rsp_d;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic out_free;
	logic fire_s1;

	arfc_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	assign out_free = !rsp_valid_q || rsp_ready;
	assign fire_s1 = valid_s1 && ((req_s1.kind == KIND_REPORT) || out_free);
	assign req_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	arfc_core #(
		.NUM_ANCHORS(NUM_ANCHORS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire_s1),
		.req(req_s1),
		.cfg(cfg),
		.rsp(rsp_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire_s1 && (req_s1.kind == KIND_EVAL)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && (req_s1.kind == KIND_EVAL)) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/arfc_checker.sv =====
// port-level checker for the collector, bound to the top level
`default_nettype none

module arfc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire arfc_pkg::rsp_t rsp
);
	import arfc_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response dropped or changed while stalled");

	a_rssi_gated: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.all_fresh |->
			rsp.rssi_first == '0 && rsp.rssi_second == '0 && rsp.rssi_third == '0)
		else $error("rssi triple shown without all anchors fresh");

	a_status_gated: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.status_due |->
			!rsp.mobile_working && rsp.status_first == ST_NOT_CONNECTED &&
			rsp.status_second == ST_NOT_CONNECTED && rsp.status_third == ST_NOT_CONNECTED)
		else $error("status fields set without status due");

	a_count_all: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.all_fresh == (rsp.fresh_count == 2'd3)))
		else $error("fresh count disagrees with all-fresh flag");

endmodule

bind anchor_rssi_freshness_collector arfc_checker u_arfc_checker (.*);

`default_nettype wire

// ===== tb/anchor_rssi_freshness_collector_tb.sv =====
// testbench: anchor rssi freshness collector, directed table then randomized reports and passes
`timescale 1ns / 1ps

module anchor_rssi_freshness_collector_tb;
	import arfc_pkg::*;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	anchor_rssi_freshness_collector i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	typedef struct {
		logic kind;
		logic [7:0] idx;
		logic signed [15:0] rssi;
		logic [31:0] now_ms;
		bit typed;
		rsp_t rsp;
	} dir_row_t;

	localparam rsp_t RSP_NONE = '0;
	localparam rsp_t RSP_DUE_ONLY = '{1'b0, 16'sd0, 16'sd0, 16'sd0, 2'd0, 1'b1, 1'b0,
		ST_NOT_CONNECTED, ST_NOT_CONNECTED, ST_NOT_CONNECTED};
	localparam rsp_t RSP_ALL_FRESH = '{1'b1, -16'sd40, -16'sd50, -16'sd60, 2'd3, 1'b0, 1'b0,
		ST_NOT_CONNECTED, ST_NOT_CONNECTED, ST_NOT_CONNECTED};

	localparam int N_DIR = 22;
	localparam int N_PHASES = 6;
	localparam int PHASE_ITEMS = 135;

	dir_row_t dir_tab [N_DIR] = '{
		'{KIND_EVAL, 8'd0, 16'sd0, 32'd0, 1'b1, RSP_NONE},
		'{KIND_EVAL, 8'd0, 16'sd0, 32'd1000, 1'b1, RSP_DUE_ONLY},
		'{KIND_REPORT, 8'd3, 16'sd5, 32'd1100, 1'b0, RSP_NONE},
		'{KIND_REPORT, 8'd255, -16'sd32768, 32'd1100, 1'b0, RSP_NONE},
		'{KIND_REPORT, 8'd0, READY_MARK, 32'd1100, 1'b0, RSP_NONE},
		'{KIND_REPORT, 8'd1, UNAVAIL_MARK, 32'd1100, 1'b0, RSP_NONE},
		'{KIND_REPORT, 8'd2, -16'sd32768, 32'd1100, 1'b0, RSP_NONE},
		'{KIND_EVAL, 8'd0, 16'sd0, 32'd1200, 1'b0, RSP_NONE},
		'{KIND_EVAL, 8'd0, 16'sd0, 32'd2100, 1'b0, RSP_NONE},
		'{KIND_REPORT, 8'd0, -16'sd40, 32'd2200, 1'b0, RSP_NONE},
		'{KIND_REPORT, 8'd1, -16'sd50, 32'd2200, 1'b0, RSP_NONE},
		'{KIND_REPORT, 8'd2, -16'sd60, 32'd2250, 1'b0, RSP_NONE},
		'{KIND_EVAL, 8'd0, 16'sd0, 32'd2400, 1'b1, RSP_ALL_FRESH},
		'{KIND_EVAL, 8'd0, 16'sd0, 32'd2401, 1'b0, RSP_NONE},
		'{KIND_REPORT, 8'd0, 16'sd32766, 32'd2500, 1'b0, RSP_NONE},
		'{KIND_EVAL, 8'd0, 16'sd0, 32'd2701, 1'b0, RSP_NONE},
		'{KIND_EVAL, 8'd0, 16'sd0, 32'd3100, 1'b0, RSP_NONE},
		'{KIND_REPORT, 8'd1, -16'sd1, 32'hFFFF_FFF0, 1'b0, RSP_NONE},
		'{KIND_REPORT, 8'd2, 16'sd0, 32'hFFFF_FFF8, 1'b0, RSP_NONE},
		'{KIND_REPORT, 8'd0, -16'sd100, 32'hFFFF_FFFF, 1'b0, RSP_NONE},
		'{KIND_EVAL, 8'd0, 16'sd0, 32'h0000_00C0, 1'b0, RSP_NONE},
		'{KIND_EVAL, 8'd0, 16'sd0, 32'h0000_0010, 1'b0, RSP_NONE}
	};

	// predicted collector state
	logic signed [15:0] anc_rssi [MAX_ANCHORS];
	bit anc_rcvd [MAX_ANCHORS];
	bit anc_ready [MAX_ANCHORS];
	logic [31:0] anc_time [MAX_ANCHORS];
	logic [31:0] mobile_time;
	logic [31:0] status_time;
	bit mobile_seen;
	cfg_t cur_cfg;

	rsp_t pending_rsp_q [$];
	int fails;
	bit sender_calm;
	logic [31:0] clock_ms;

	function automatic void reset_collector();
		for (int i = 0; i < MAX_ANCHORS; i++) begin
			anc_rssi[i] = RSSI_RESET;
			anc_rcvd[i] = 1'b0;
			anc_ready[i] = 1'b0;
			anc_time[i] = '0;
		end
		mobile_time = '0;
		status_time = '0;
		mobile_seen = 1'b0;
		cur_cfg.fresh_timeout_ms = FRESH_TIMEOUT_RST;
		cur_cfg.mobile_timeout_ms = MOBILE_TIMEOUT_RST;
		cur_cfg.status_interval_ms = STATUS_INTERVAL_RST;
	endfunction

	function automatic void collect(input req_t r, output bit has, output rsp_t e);
		bit recent [MAX_ANCHORS];
		bit fresh [MAX_ANCHORS];
		anc_status_t st [MAX_ANCHORS];
		bit all;
		bit due;
		logic [1:0] cnt;
		logic [31:0] age;
		int a;
		e = '0;
		has = 1'b0;
		if (r.kind == KIND_REPORT) begin
			a = int'(r.anchor_index);
			if (a < NUM_ANCHORS_DEF) begin
				anc_ready[a] = 1'b1;
				if (r.rssi_value != READY_MARK) begin
					if (r.rssi_value != UNAVAIL_MARK)
						anc_rssi[a] = r.rssi_value;
					anc_rcvd[a] = 1'b1;
					anc_time[a] = r.now_ms;
					mobile_time = r.now_ms;
					mobile_seen = 1'b1;
				end
			end
		end else begin
			has = 1'b1;
			all = 1'b1;
			cnt = '0;
			for (int i = 0; i < MAX_ANCHORS; i++) begin
				age = r.now_ms - anc_time[i];
				recent[i] = anc_rcvd[i] && (age <= {16'h0, cur_cfg.fresh_timeout_ms});
				fresh[i] = recent[i] && (anc_rssi[i] != UNAVAIL_MARK);
				if (fresh[i])
					cnt = cnt + 2'd1;
				else
					all = 1'b0;
				st[i] = ST_NOT_CONNECTED;
			end
			age = r.now_ms - status_time;
			due = age >= {16'h0, cur_cfg.status_interval_ms};
			if (due) begin
				status_time = r.now_ms;
				age = r.now_ms - mobile_time;
				e.mobile_working = mobile_seen && (age <= {16'h0, cur_cfg.mobile_timeout_ms});
				for (int i = 0; i < MAX_ANCHORS; i++) begin
					if (!anc_ready[i])
						st[i] = ST_NOT_CONNECTED;
					else if (recent[i] && anc_rssi[i] == UNAVAIL_MARK)
						st[i] = ST_RX_NO_RSSI;
					else if (fresh[i])
						st[i] = ST_FRESH;
					else if (anc_rcvd[i])
						st[i] = ST_STALE;
					else
						st[i] = ST_WAITING;
				end
			end
			e.all_fresh = all;
			if (all) begin
				e.rssi_first = anc_rssi[0];
				e.rssi_second = anc_rssi[1];
				e.rssi_third = anc_rssi[2];
				for (int i = 0; i < MAX_ANCHORS; i++)
					anc_rcvd[i] = 1'b0;
			end
			e.fresh_count = cnt;
			e.status_due = due;
			e.status_first = st[0];
			e.status_second = st[1];
			e.status_third = st[2];
		end
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		if (p < 98)
			return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	// kind_sel / idx_sel below zero mean random
	function automatic req_t gen_req(input int kind_sel, input int idx_sel);
		req_t r;
		int p;
		p = $urandom_range(0, 99);
		if (kind_sel >= 0 || p < 30)
			clock_ms = clock_ms + $urandom_range(0, 3);
		else if (p < 80)
			clock_ms = clock_ms + $urandom_range(1, 300);
		else if (p < 95)
			clock_ms = clock_ms + $urandom_range(301, 5000);
		else
			clock_ms = $urandom();
		r.now_ms = clock_ms;
		if (kind_sel >= 0)
			r.kind = kind_sel[0];
		else
			r.kind = ($urandom_range(0, 99) < 35) ? KIND_EVAL : KIND_REPORT;
		if (idx_sel >= 0)
			r.anchor_index = idx_sel[7:0];
		else if ($urandom_range(0, 9) != 0)
			r.anchor_index = 8'($urandom_range(0, NUM_ANCHORS_DEF - 1));
		else
			r.anchor_index = 8'($urandom_range(0, 255));
		p = $urandom_range(0, 99);
		if (p < 10)
			r.rssi_value = READY_MARK;
		else if (p < 20)
			r.rssi_value = UNAVAIL_MARK;
		else if (p < 23)
			r.rssi_value = -16'sd32768;
		else if (p < 26)
			r.rssi_value = 16'sd32766;
		else if (p < 65)
			r.rssi_value = -$signed({1'b0, 15'($urandom_range(20, 110))});
		else
			r.rssi_value = 16'($urandom());
		return r;
	endfunction

	task automatic send_req(input req_t r, input bit typed, input rsp_t typed_rsp);
		int gap;
		bit has;
		rsp_t e;
		gap = sender_calm ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		collect(r, has, e);
		if (has)
			pending_rsp_q.push_back(typed ? typed_rsp : e);
	endtask

	task automatic cfg_write(input logic [1:0] reg_idx, input logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= {16'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (reg_idx)
			REG_FRESH_TIMEOUT: cur_cfg.fresh_timeout_ms = val;
			REG_MOBILE_TIMEOUT: cur_cfg.mobile_timeout_ms = val;
			REG_STATUS_INTERVAL: cur_cfg.status_interval_ms = val;
			default: ;
		endcase
	endtask

	task automatic cmp_field(input string fname, input int e, input int a);
		if (e != a) begin
			$error("%s: expected %0d, actual %0d", fname, e, a);
			fails++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("anchor_rssi_freshness_collector regression: fail");
		$finish;
	end

	// response checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp_q.size() == 0) begin
				$error("response with no request waiting");
				fails++;
			end else begin
				rsp_t e;
				e = pending_rsp_q.pop_front();
				cmp_field("all_fresh", int'(e.all_fresh), int'(rsp.all_fresh));
				cmp_field("rssi_first", int'(e.rssi_first), int'(rsp.rssi_first));
				cmp_field("rssi_second", int'(e.rssi_second), int'(rsp.rssi_second));
				cmp_field("rssi_third", int'(e.rssi_third), int'(rsp.rssi_third));
				cmp_field("fresh_count", int'(e.fresh_count), int'(rsp.fresh_count));
				cmp_field("status_due", int'(e.status_due), int'(rsp.status_due));
				cmp_field("mobile_working", int'(e.mobile_working),
					int'(rsp.mobile_working));
				cmp_field("status_first", int'(e.status_first), int'(rsp.status_first));
				cmp_field("status_second", int'(e.status_second), int'(rsp.status_second));
				cmp_field("status_third", int'(e.status_third), int'(rsp.status_third));
			end
		end
	end

	// response side backpressure
	initial begin
		int run;
		int gap;
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			run = $urandom_range(1, 40);
			rsp_ready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		req_t r;
		int sent;
		logic [15:0] f_to;
		logic [15:0] m_to;
		logic [15:0] s_iv;
		fails = 0;
		sender_calm = 1'b0;
		clock_ms = 32'd5000;
		reset_collector();
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			r.kind = dir_tab[i].kind;
			r.anchor_index = dir_tab[i].idx;
			r.rssi_value = dir_tab[i].rssi;
			r.now_ms = dir_tab[i].now_ms;
			send_req(r, dir_tab[i].typed, dir_tab[i].rsp);
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			req_valid <= 1'b0;
			while (pending_rsp_q.size() != 0) @(posedge clk);
			repeat (4) @(posedge clk);
			case (ph)
				0: begin f_to = 16'd0; m_to = 16'd0; s_iv = 16'd0; end
				1: begin f_to = 16'hFFFF; m_to = 16'hFFFF; s_iv = 16'hFFFF; end
				2: begin f_to = 16'd50; m_to = 16'd400; s_iv = 16'd300; end
				3: begin f_to = 16'd1; m_to = 16'hFFFF; s_iv = 16'd1; end
				4: begin
					f_to = 16'($urandom_range(0, 2000));
					m_to = 16'($urandom_range(0, 4000));
					s_iv = 16'($urandom_range(0, 3000));
				end
				default: begin
					f_to = FRESH_TIMEOUT_RST;
					m_to = MOBILE_TIMEOUT_RST;
					s_iv = STATUS_INTERVAL_RST;
				end
			endcase
			cfg_write(REG_FRESH_TIMEOUT, f_to);
			cfg_write(REG_MOBILE_TIMEOUT, m_to);
			cfg_write(REG_STATUS_INTERVAL, s_iv);
			sender_calm = ($urandom_range(0, 2) == 0);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 3) == 0) begin
					// full round: one report per anchor, then a pass
					for (int a = 0; a < NUM_ANCHORS_DEF; a++)
						send_req(gen_req(int'(KIND_REPORT), a), 1'b0, RSP_NONE);
					send_req(gen_req(int'(KIND_EVAL), 0), 1'b0, RSP_NONE);
					sent += NUM_ANCHORS_DEF + 1;
				end else begin
					send_req(gen_req(-1, -1), 1'b0, RSP_NONE);
					sent++;
				end
			end
		end

		req_valid <= 1'b0;
		while (pending_rsp_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("anchor_rssi_freshness_collector regression: pass");
		else
			$display("anchor_rssi_freshness_collector regression: fail");
		$finish;
	end

endmodule
